// ===== sv/pcd_pkg.sv =====
// ----------------------------------------------------------------------------
// pcd_pkg
// Shared types and constants for the polyline coordinate decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package pcd_pkg;

  localparam int unsigned CharW      = 8;
  localparam int unsigned LimitW     = 31;
  localparam int unsigned ValueW     = 32;
  localparam int unsigned CountW     = 3;
  localparam int unsigned ChunkW     = 5;
  localparam int unsigned OutSumW    = 40;
  localparam int unsigned CfgIndexW  = 2;

  localparam logic [CountW-1:0] MaxChunks  = 3'd7;
  localparam logic [CharW-1:0]  ChunkBias  = 8'd63;
  localparam logic [CharW-1:0]  CloseBound = 8'd95;
  localparam logic [CharW-1:0]  Backslash  = 8'd92;

  localparam logic [LimitW-1:0] LatLimitReset = 31'd9000000;
  localparam logic [LimitW-1:0] LonLimitReset = 31'd18000000;

  // Configuration register indexes.
  localparam logic [CfgIndexW-1:0] CFG_UNESCAPE  = 2'd0;
  localparam logic [CfgIndexW-1:0] CFG_LAT_LIMIT = 2'd1;
  localparam logic [CfgIndexW-1:0] CFG_LON_LIMIT = 2'd2;

  typedef enum logic [1:0] {
    ST_MID   = 2'd0,
    ST_DONE  = 2'd1,
    ST_ERROR = 2'd2
  } status_t;

  typedef struct packed {
    logic                    unescape_en;
    logic [LimitW-1:0]       lat_limit;
    logic [LimitW-1:0]       lon_limit;
  } cfg_t;

  typedef struct packed {
    logic signed [OutSumW-1:0] lat_sum;
    logic signed [OutSumW-1:0] lon_sum;
    logic                      has_location;
    status_t                   status;
    logic                      final_result;
  } res_t;

endpackage

`default_nettype wire

// ===== sv/polyline_coordinate_decoder_core.sv =====
// ----------------------------------------------------------------------------
// polyline_coordinate_decoder_core
// Streaming decoder for encoded polyline text with integer coordinates.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake            Payload
//  in       input      in_valid/in_stall    char_code, last_char
//  out      output     out_valid/out_stall  lat_sum, lon_sum, has_location,
//                                           status, final_result
//  cfg      input      cfg_we               cfg_index, cfg_wdata
//
//  One character item per cycle unless a full result register is stalled:
//  input register, decode logic, then the result register, which is loaded
//  only when an item completes a location or ends in an error.
//  The decode stage's running-sum adder and limit compare set the cycle time.
//  A full result register that is stalled holds the decode stage and then
//  the input register. Synchronous active-low reset clears all polyline
//  state and loads the default limits.
// ----------------------------------------------------------------------------
`default_nettype none

module polyline_coordinate_decoder_core
  import pcd_pkg::*;
#(
  parameter int unsigned SUM_BITS = 40
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [CharW-1:0]      in_char_code,
  input  wire logic                  in_last_char,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic signed [OutSumW-1:0]  out_lat_sum,
  output logic signed [OutSumW-1:0]  out_lon_sum,
  output logic                       out_has_location,
  output logic [1:0]                 out_status,
  output logic                       out_final_result,
  input  wire logic                  cfg_we,
  input  wire logic [CfgIndexW-1:0]  cfg_index,
  input  wire logic [LimitW-1:0]     cfg_wdata
);

  cfg_t             cfg_r;
  logic             s1_valid;
  logic [CharW-1:0] s1_char;
  logic             s1_last;
  logic             can_load;
  logic             fire;
  logic             res_emit;
  res_t             res;
  res_t             res_out;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.unescape_en <= 1'b0;
      cfg_r.lat_limit   <= LatLimitReset;
      cfg_r.lon_limit   <= LonLimitReset;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_UNESCAPE:  cfg_r.unescape_en <= cfg_wdata[0];
        CFG_LAT_LIMIT: cfg_r.lat_limit   <= cfg_wdata;
        CFG_LON_LIMIT: cfg_r.lon_limit   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // The decode stage runs whenever it holds an item and the result register can take its output.
  assign fire = s1_valid && can_load;

  pcd_in_reg u_in (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_char_code (in_char_code),
    .in_last_char (in_last_char),
    .take         (fire),
    .s1_valid     (s1_valid),
    .s1_char      (s1_char),
    .s1_last      (s1_last)
  );

  pcd_decode #(
    .SUM_BITS (SUM_BITS)
  ) u_dec (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .char_code (s1_char),
    .last_char (s1_last),
    .cfg       (cfg_r),
    .res_emit  (res_emit),
    .res       (res)
  );

  pcd_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (fire && res_emit),
    .res_in    (res),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .res_out   (res_out)
  );

  assign out_lat_sum      = res_out.lat_sum;
  assign out_lon_sum      = res_out.lon_sum;
  assign out_has_location = res_out.has_location;
  assign out_status       = res_out.status;
  assign out_final_result = res_out.final_result;

`ifndef SYNTH
  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid && out_valid && out_stall))
    else $error("core: input stalled without a blocked result");

  a_no_fire_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_final_result)))
    else $error("core: held result changed under stall");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_has_location || out_status == ST_ERROR))
    else $error("core: result with neither location nor error");
`endif

endmodule

`default_nettype wire

// ===== sv/pcd_in_reg.sv =====
// ----------------------------------------------------------------------------
// pcd_in_reg
// Input register stage: captures one character item and holds it until the
// decode stage consumes it.
// ----------------------------------------------------------------------------
`default_nettype none

module pcd_in_reg
  import pcd_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic [CharW-1:0] in_char_code,
  input  wire logic             in_last_char,
  input  wire logic             take,
  output logic                  s1_valid,
  output logic [CharW-1:0]      s1_char,
  output logic                  s1_last
);

  logic             valid_r, valid_nxt;
  logic [CharW-1:0] char_r;
  logic             last_r;
  logic             load;

  // The stage may refill in the same cycle that the decode stage takes it.
  assign in_stall = valid_r && !take;
  assign load     = in_valid && !in_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      char_r <= in_char_code;
      last_r <= in_last_char;
    end
  end

  assign s1_valid = valid_r;
  assign s1_char  = char_r;
  assign s1_last  = last_r;

endmodule

`default_nettype wire

// ===== sv/pcd_decode.sv =====
// ----------------------------------------------------------------------------
// pcd_decode
// Per-character decode: chunk merge, zigzag undo, limit check and running
// sums, with the per-polyline state registers.
// ----------------------------------------------------------------------------
`default_nettype none

module pcd_decode
  import pcd_pkg::*;
#(
  parameter int unsigned SUM_BITS = 40
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             fire,
  input  wire logic [CharW-1:0] char_code,
  input  wire logic             last_char,
  input  wire cfg_t             cfg,
  output logic                  res_emit,
  output res_t                  res
);

  logic [ValueW-1:0]          accum_r, accum_nxt;
  logic [CountW-1:0]          count_r, count_nxt;
  logic                       want_lon_r, want_lon_nxt;
  logic signed [ValueW-1:0]   pend_lat_r, pend_lat_nxt;
  logic signed [SUM_BITS-1:0] lat_total_r, lat_total_nxt;
  logic signed [SUM_BITS-1:0] lon_total_r, lon_total_nxt;
  logic                       esc_r, esc_nxt;
  logic                       disc_r, disc_nxt;

  logic [ChunkW-1:0]          chunk;
  logic [ChunkW-1:0]          shamt;
  logic [ValueW-1:0]          merged;
  logic signed [ValueW-1:0]   half;
  logic signed [ValueW-1:0]   delta;
  logic [ValueW-1:0]          mag;
  logic                       lat_ok;
  logic                       lon_ok;
  logic                       is_bs;
  logic                       closes;
  logic signed [SUM_BITS-1:0] lat_new;
  logic signed [SUM_BITS-1:0] lon_new;

  // Datapath shared by every branch below.
  assign chunk  = char_code[ChunkW-1:0] - ChunkBias[ChunkW-1:0];
  assign shamt  = ({2'b00, count_r} << 2) + {2'b00, count_r};
  assign merged = accum_r | (ValueW'(chunk) << shamt);
  assign half   = $signed(merged) >>> 1;
  assign delta  = merged[0] ? ~half : half;
  assign mag    = delta[ValueW-1] ? (ValueW'(0) - delta) : delta;
  assign lat_ok = mag <= {1'b0, cfg.lat_limit};
  assign lon_ok = mag <= {1'b0, cfg.lon_limit};
  assign is_bs  = char_code == Backslash;
  assign closes = char_code < CloseBound;
  assign lat_new = lat_total_r + SUM_BITS'(pend_lat_r);
  assign lon_new = lon_total_r + SUM_BITS'(delta);

  always_comb begin
    logic err;
    logic restart;
    logic go;
    err           = 1'b0;
    restart       = 1'b0;
    go            = 1'b0;
    accum_nxt     = accum_r;
    count_nxt     = count_r;
    want_lon_nxt  = want_lon_r;
    pend_lat_nxt  = pend_lat_r;
    lat_total_nxt = lat_total_r;
    lon_total_nxt = lon_total_r;
    esc_nxt       = esc_r;
    disc_nxt      = disc_r;
    res_emit      = 1'b0;
    res           = '0;
    res.status    = ST_MID;

    if (disc_r) begin
      // Skip the rest of a failed polyline up to its last character.
      if (last_char) begin
        restart  = 1'b1;
        disc_nxt = 1'b0;
      end
    end else begin
      if (esc_r) begin
        esc_nxt = 1'b0;
        if (!is_bs) begin
          err = 1'b1;
        end else begin
          go = 1'b1;
        end
      end else if (cfg.unescape_en && is_bs) begin
        esc_nxt = 1'b1;
        err     = last_char;
      end else begin
        go = 1'b1;
      end

      if (go) begin
        if (count_r >= MaxChunks) begin
          err = 1'b1;
        end else if (!closes) begin
          accum_nxt = merged;
          count_nxt = count_r + 3'd1;
          err       = last_char;
        end else begin
          accum_nxt = '0;
          count_nxt = '0;
          if (!want_lon_r) begin
            if (last_char || !lat_ok) begin
              err = 1'b1;
            end else begin
              pend_lat_nxt = delta;
              want_lon_nxt = 1'b1;
            end
          end else if (!lon_ok) begin
            err = 1'b1;
          end else begin
            want_lon_nxt     = 1'b0;
            lat_total_nxt    = lat_new;
            lon_total_nxt    = lon_new;
            res_emit         = 1'b1;
            res.lat_sum      = OutSumW'(lat_new);
            res.lon_sum      = OutSumW'(lon_new);
            res.has_location = 1'b1;
            res.status       = last_char ? ST_DONE : ST_MID;
            res.final_result = last_char;
            restart          = last_char;
          end
        end
      end

      if (err) begin
        res_emit         = 1'b1;
        res              = '0;
        res.status       = ST_ERROR;
        res.final_result = 1'b1;
        restart          = 1'b1;
        disc_nxt         = !last_char;
      end
    end

    if (restart) begin
      accum_nxt     = '0;
      count_nxt     = '0;
      want_lon_nxt  = 1'b0;
      pend_lat_nxt  = '0;
      lat_total_nxt = '0;
      lon_total_nxt = '0;
      esc_nxt       = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accum_r     <= '0;
      count_r     <= '0;
      want_lon_r  <= 1'b0;
      pend_lat_r  <= '0;
      lat_total_r <= '0;
      lon_total_r <= '0;
      esc_r       <= 1'b0;
      disc_r      <= 1'b0;
    end else if (fire) begin
      accum_r     <= accum_nxt;
      count_r     <= count_nxt;
      want_lon_r  <= want_lon_nxt;
      pend_lat_r  <= pend_lat_nxt;
      lat_total_r <= lat_total_nxt;
      lon_total_r <= lon_total_nxt;
      esc_r       <= esc_nxt;
      disc_r      <= disc_nxt;
    end
  end

`ifndef SYNTH
  // While skipping a failed polyline, the value and pair state stay cleared.
  a_disc_clean: assert property (@(posedge clk) disable iff (!rst_n)
    disc_r |-> (!esc_r && count_r == '0 && !want_lon_r && accum_r == '0))
    else $error("pcd_decode: state not cleared while discarding");

  a_err_final: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && res_emit && res.status == ST_ERROR) |->
      (res.final_result && !res.has_location))
    else $error("pcd_decode: error result not marked final");

  a_final_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && res_emit && res.final_result) |=>
      (lat_total_r == '0 && lon_total_r == '0 && !want_lon_r))
    else $error("pcd_decode: polyline state kept after final result");

  a_location_pair: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && res_emit && res.has_location) |-> want_lon_r)
    else $error("pcd_decode: location given without a pending latitude");
`endif

endmodule

`default_nettype wire

// ===== sv/pcd_out_reg.sv =====
// ----------------------------------------------------------------------------
// pcd_out_reg
// Result register: holds one decoded item until the consumer takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module pcd_out_reg
  import pcd_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic load,
  input  wire res_t res_in,
  output logic      can_load,
  output logic      out_valid,
  input  wire logic out_stall,
  output res_t      res_out
);

  logic valid_r, valid_nxt;
  res_t res_r;

  assign can_load = !valid_r || !out_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (valid_r && !out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_in;
    end
  end

  assign out_valid = valid_r;
  assign res_out   = res_r;

endmodule

`default_nettype wire
